// ----- design/haversine_distance_accumulator_assert.svh -----
// ----------------------------------------------------------------------------
// Haversine distance accumulator assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_ACCUMULATOR_ASSERT_SVH
`define HAVERSINE_DISTANCE_ACCUMULATOR_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define HDA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("haversine accumulator check failed");

// Check that a condition implies another in the next cycle.
`define HDA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("haversine accumulator check failed");

`endif

// ----- design/hda_pkg.sv -----
// ----------------------------------------------------------------------------
// Haversine distance accumulator package
// Widths, angle constants, sequencer types and the elaboration-time
// functions that build the CORDIC arctangent table and start vector.
// ----------------------------------------------------------------------------
package hda_pkg;

	// Iteration count and arctangent table size
	localparam int CORDIC_ITERATIONS_DEF = 24;
	localparam int TBL_LEN = 64;
	localparam int IT_W = 6;

	// Field widths
	localparam int LAT_W = 30;
	localparam int LON_W = 31;
	localparam int STEP_W = 31;
	localparam int TOTAL_W = 48;

	// Datapath widths
	localparam int ANG_W = 34;   // angle in degrees * 2^23 during reduction
	localparam int CW = 46;      // CORDIC x, y, z at 2^40 scale
	localparam int SW = 36;      // sin, cos and products at 2^30 scale
	localparam int MB_W = 34;    // multiplier operand scanned one bit per cycle
	localparam int ACC_W = 64;   // multiplier accumulator
	localparam int SQ_W = 62;    // square root working registers
	localparam int A_W = 31;     // haversine term a at 2^30 scale

	// Angle constants, degrees * 2^23
	localparam logic signed [ANG_W-1:0] TURN_U = 34'sd3019898880;
	localparam logic signed [ANG_W-1:0] HALF_U = 34'sd1509949440;
	localparam logic signed [ANG_W-1:0] QUARTER_U = 34'sd754974720;

	localparam logic [A_W-1:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [MB_W-1:0] DIAMETER_KM = 34'd12742;
	localparam logic [SQ_W-1:0] SQ_BIT_START = 62'h1000_0000_0000_0000;

	// Angle being worked on
	localparam logic [1:0] ANG_DLAT = 2'd0;
	localparam logic [1:0] ANG_DLON = 2'd1;
	localparam logic [1:0] ANG_LAT_A = 2'd2;
	localparam logic [1:0] ANG_LAT_B = 2'd3;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RED  = 6'b000010,
		S_MUL  = 6'b000100,
		S_CORD = 6'b001000,
		S_SQRT = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	// What the multiplier result feeds
	typedef enum logic [2:0] {
		TAG_RAD = 3'd0,
		TAG_S1  = 3'd1,
		TAG_S2  = 3'd2,
		TAG_C   = 3'd3,
		TAG_A   = 3'd4,
		TAG_D   = 3'd5
	} mul_tag_t;

	typedef logic [63:0] atan_tbl_t [TBL_LEN];

	// Restoring long division, used at elaboration only
	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		int i;
		q = '0;
		r = '0;
		for (i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Floor square root of a 64-bit value
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		logic [63:0] rem;
		int i;
		res = '0;
		rem = v;
		bitv = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (bitv > rem)
				bitv = bitv >> 2;
		end
		for (i = 0; i < 32; i++) begin
			if (bitv != 0) begin
				if (rem >= res + bitv) begin
					rem = rem - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return res;
	endfunction

	// atan(1/n) * 2^60 by its alternating series
	function automatic logic [63:0] recip_atan_q60(input logic [63:0] n);
		logic [63:0] term;
		logic [63:0] sum;
		int k;
		term = udiv(64'd1 << 60, n);
		sum = term;
		for (k = 1; k < 64; k++) begin
			if (term != 0) begin
				term = udiv(udiv(term, n), n);
				if (k % 2 == 1)
					sum = sum - udiv(term, 64'(2 * k + 1));
				else
					sum = sum + udiv(term, 64'(2 * k + 1));
			end
		end
		return sum;
	endfunction

	// atan(2^-i) * 2^40, rounded
	function automatic atan_tbl_t build_atan_tbl();
		atan_tbl_t tbl;
		logic [63:0] v;
		int i;
		for (i = 0; i < TBL_LEN; i++) begin
			if (i == 0)
				v = recip_atan_q60(64'd2) + recip_atan_q60(64'd3);
			else
				v = recip_atan_q60(64'd1 << i);
			tbl[i] = (v + (64'd1 << 19)) >> 20;
		end
		return tbl;
	endfunction

	// Radians per angle unit, 2^60 scale
	function automatic logic [63:0] rad_per_unit();
		logic [63:0] pi_q60;
		logic [63:0] half;
		pi_q60 = 64'd4 * (recip_atan_q60(64'd2) + recip_atan_q60(64'd3));
		half = 64'(HALF_U);
		return udiv(pi_q60 + (half >> 1), half);
	endfunction

	// Inverse CORDIC gain for n iterations, 2^40 scale
	function automatic logic [63:0] inv_gain_q40(input int n);
		logic [63:0] g;
		int m;
		int i;
		m = (n > TBL_LEN) ? TBL_LEN : n;
		g = 64'd1 << 60;
		for (i = 0; i < m; i++) begin
			if (2 * i < 64)
				g = g + (g >> (2 * i));
		end
		return udiv(64'd1 << 62, isqrt64(g)) << 8;
	endfunction

endpackage

// ----- design/haversine_distance_accumulator.sv -----
// ----------------------------------------------------------------------------
// Haversine distance accumulator
// Great-circle distance between two fixed-point positions, added into a
// saturating running total.
// ----------------------------------------------------------------------------
// One shared unit set does all the work: a shift-and-add multiplier that
// scans one operand bit per cycle (nine products per item), one CORDIC
// stage used once per iteration for four sin/cos evaluations and one atan2,
// and a one-step-per-cycle square root (two roots of 31 steps). A new beat
// is taken as soon as the previous result sits in the output register, even
// if it is not yet taken. total_distance is the running total after the last
// delivered step and saturates at 2^48 - 1 until reset.
module haversine_distance_accumulator #(
	parameter int CORDIC_ITERATIONS = hda_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [hda_pkg::LAT_W-1:0]   start_latitude,
	input  logic signed [hda_pkg::LON_W-1:0]   start_longitude,
	input  logic signed [hda_pkg::LAT_W-1:0]   end_latitude,
	input  logic signed [hda_pkg::LON_W-1:0]   end_longitude,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic        [hda_pkg::STEP_W-1:0]  step_distance,
	output logic        [hda_pkg::TOTAL_W-1:0] total_distance
);

	localparam int IT_W = hda_pkg::IT_W;
	localparam int ANG_W = hda_pkg::ANG_W;
	localparam int CW = hda_pkg::CW;
	localparam int SW = hda_pkg::SW;
	localparam int MB_W = hda_pkg::MB_W;
	localparam int ACC_W = hda_pkg::ACC_W;
	localparam int SQ_W = hda_pkg::SQ_W;
	localparam int A_W = hda_pkg::A_W;
	localparam int STEP_W = hda_pkg::STEP_W;
	localparam int TOTAL_W = hda_pkg::TOTAL_W;

	localparam hda_pkg::atan_tbl_t ATAN_TBL = hda_pkg::build_atan_tbl();
	localparam logic [63:0] RAD_PER_UNIT = hda_pkg::rad_per_unit();
	localparam logic [63:0] INV_GAIN = hda_pkg::inv_gain_q40(CORDIC_ITERATIONS);
	localparam logic [IT_W-1:0] ITER_LAST = IT_W'(CORDIC_ITERATIONS - 1);

	function automatic logic [SW-1:0] mag_s(input logic signed [SW-1:0] v);
		return v[SW-1] ? -v : v;
	endfunction

	// Control state
	hda_pkg::state_t state_q;
	logic out_valid_q;
	logic [TOTAL_W-1:0] total_q;

	// Input beat
	logic signed [hda_pkg::LAT_W-1:0] lat_a_q;
	logic signed [hda_pkg::LON_W-1:0] lon_a_q;
	logic signed [hda_pkg::LAT_W-1:0] lat_b_q;
	logic signed [hda_pkg::LON_W-1:0] lon_b_q;
	logic [1:0] ang_q;
	logic fold_q;

	// Multiplier
	logic [ACC_W-1:0] mul_a_q;
	logic [MB_W-1:0] mul_b_q;
	logic [ACC_W-1:0] mul_acc_q;
	logic mul_neg_q;
	hda_pkg::mul_tag_t mul_tag_q;

	// CORDIC
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [IT_W-1:0] it_q;
	logic rot_q;

	// Intermediate terms
	logic signed [SW-1:0] s1_q, s2_q, c1_q, c2_q, t1_q, t2_q;
	logic [A_W-1:0] a_q;
	logic [A_W-1:0] ry_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] out_step_q;

	// Square root
	logic [SQ_W-1:0] sq_v_q, sq_res_q, sq_bit_q;
	logic sq_sel_q;

	// Angle reduction
	logic signed [ANG_W-1:0] ang, r1, r2;
	logic red_fold;
	logic [MB_W-1:0] red_mag;

	always_comb begin
		case (ang_q)
			hda_pkg::ANG_DLAT: ang = ANG_W'(lat_b_q) - ANG_W'(lat_a_q);
			hda_pkg::ANG_DLON: ang = ANG_W'(lon_b_q) - ANG_W'(lon_a_q);
			hda_pkg::ANG_LAT_A: ang = ANG_W'(lat_a_q) <<< 1;
			default: ang = ANG_W'(lat_b_q) <<< 1;
		endcase
		// wrap into a half turn either side
		r1 = ang;
		if (ang <= -hda_pkg::HALF_U)
			r1 = ang + hda_pkg::TURN_U;
		else if (ang > hda_pkg::HALF_U)
			r1 = ang - hda_pkg::TURN_U;
		// fold into a quarter turn, flipping the sign of the result
		r2 = r1;
		red_fold = 1'b0;
		if (r1 > hda_pkg::QUARTER_U) begin
			r2 = r1 - hda_pkg::HALF_U;
			red_fold = 1'b1;
		end else if (r1 < -hda_pkg::QUARTER_U) begin
			r2 = r1 + hda_pkg::HALF_U;
			red_fold = 1'b1;
		end
		red_mag = MB_W'(r2[ANG_W-1] ? -r2 : r2);
	end

	// Signed product and its roundings
	logic signed [ACC_W:0] prod_s;
	logic signed [ACC_W:0] prod_r20, prod_r30;
	logic signed [CW-1:0] rnd20;
	logic signed [SW-1:0] rnd30;
	logic mul_done;

	assign mul_done = (mul_b_q == '0);
	assign prod_s = mul_neg_q ? -$signed({1'b0, mul_acc_q}) : $signed({1'b0, mul_acc_q});
	assign prod_r20 = (prod_s + $signed((ACC_W + 1)'(1 << 19))) >>> 20;
	assign prod_r30 = (prod_s + $signed((ACC_W + 1)'(1 << 29))) >>> 30;
	assign rnd20 = CW'(prod_r20);
	assign rnd30 = SW'(prod_r30);

	// Haversine term a, clamped to [0, 1]
	logic signed [SW:0] a_sum;
	logic [A_W-1:0] a_clamp;

	always_comb begin
		a_sum = (SW + 1)'(t1_q) + (SW + 1)'(rnd30);
		if (a_sum[SW])
			a_clamp = '0;
		else if (a_sum > $signed((SW + 1)'(hda_pkg::ONE_Q30)))
			a_clamp = hda_pkg::ONE_Q30;
		else
			a_clamp = A_W'(a_sum);
	end

	// Step distance from the scaled angle
	logic [ACC_W-1:0] step_raw;
	logic [STEP_W-1:0] step_sat;

	assign step_raw = (mul_acc_q + ACC_W'(1 << 23)) >> 24;
	assign step_sat = (|step_raw[ACC_W-1:STEP_W]) ? '1 : step_raw[STEP_W-1:0];

	// Saturating running total
	logic [TOTAL_W:0] total_sum;
	logic [TOTAL_W-1:0] total_nx;

	assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(step_q);
	assign total_nx = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

	// One CORDIC iteration, rotation or vectoring
	logic signed [CW-1:0] sh_x, sh_y, atan_val;
	logic signed [CW-1:0] x_nx, y_nx, z_nx;
	logic signed [CW-1:0] x_rnd, y_rnd;
	logic signed [SW-1:0] sc_val, sc_res;
	logic cw_dir;
	logic cord_done;

	always_comb begin
		sh_x = x_q >>> it_q;
		sh_y = y_q >>> it_q;
		atan_val = $signed(ATAN_TBL[it_q][CW-1:0]);
		cw_dir = rot_q ? ~z_q[CW-1] : y_q[CW-1];
		if (cw_dir) begin
			x_nx = x_q - sh_y;
			y_nx = y_q + sh_x;
			z_nx = z_q - atan_val;
		end else begin
			x_nx = x_q + sh_y;
			y_nx = y_q - sh_x;
			z_nx = z_q + atan_val;
		end
		x_rnd = (x_nx + $signed(CW'(512))) >>> 10;
		y_rnd = (y_nx + $signed(CW'(512))) >>> 10;
		sc_val = (ang_q == hda_pkg::ANG_DLAT || ang_q == hda_pkg::ANG_DLON)
			? SW'(y_rnd) : SW'(x_rnd);
		sc_res = fold_q ? -sc_val : sc_val;
	end

	assign cord_done = (it_q == ITER_LAST);

	// One square root step, floor root
	logic [SQ_W-1:0] sq_try, sq_res_nx;
	logic sq_ge, sq_done;

	assign sq_try = sq_res_q + sq_bit_q;
	assign sq_ge = (sq_v_q >= sq_try);
	assign sq_res_nx = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);
	assign sq_done = sq_bit_q[0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hda_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			total_q <= '0;
		end else begin
			// drop the result once taken, unless a new one loads now
			if (out_valid_q && out_ready && state_q != hda_pkg::S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				hda_pkg::S_IDLE: begin
					if (in_valid)
						state_q <= hda_pkg::S_RED;
				end
				hda_pkg::S_RED: state_q <= hda_pkg::S_MUL;
				hda_pkg::S_MUL: begin
					if (mul_done) begin
						case (mul_tag_q)
							hda_pkg::TAG_RAD: state_q <= hda_pkg::S_CORD;
							hda_pkg::TAG_A: state_q <= hda_pkg::S_SQRT;
							hda_pkg::TAG_D: state_q <= hda_pkg::S_DONE;
							default: state_q <= hda_pkg::S_MUL;
						endcase
					end
				end
				hda_pkg::S_CORD: begin
					if (cord_done) begin
						if (rot_q && ang_q != hda_pkg::ANG_LAT_B)
							state_q <= hda_pkg::S_RED;
						else
							state_q <= hda_pkg::S_MUL;
					end
				end
				hda_pkg::S_SQRT: begin
					if (sq_done && sq_sel_q)
						state_q <= hda_pkg::S_CORD;
				end
				hda_pkg::S_DONE: begin
					// load the output register once it is free
					if (!out_valid_q || out_ready) begin
						total_q <= total_nx;
						out_valid_q <= 1'b1;
						state_q <= hda_pkg::S_IDLE;
					end
				end
				default: state_q <= hda_pkg::S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			hda_pkg::S_IDLE: begin
				if (in_valid) begin
					lat_a_q <= start_latitude;
					lon_a_q <= start_longitude;
					lat_b_q <= end_latitude;
					lon_b_q <= end_longitude;
					ang_q <= hda_pkg::ANG_DLAT;
				end
			end
			hda_pkg::S_RED: begin
				// convert the reduced angle to radians
				mul_a_q <= RAD_PER_UNIT;
				mul_b_q <= red_mag;
				mul_acc_q <= '0;
				mul_neg_q <= r2[ANG_W-1];
				mul_tag_q <= hda_pkg::TAG_RAD;
				fold_q <= red_fold;
			end
			hda_pkg::S_MUL: begin
				if (!mul_done) begin
					if (mul_b_q[0])
						mul_acc_q <= mul_acc_q + mul_a_q;
					mul_a_q <= mul_a_q << 1;
					mul_b_q <= mul_b_q >> 1;
				end else begin
					mul_acc_q <= '0;
					case (mul_tag_q)
						hda_pkg::TAG_RAD: begin
							x_q <= $signed(INV_GAIN[CW-1:0]);
							y_q <= '0;
							z_q <= rnd20;
							it_q <= '0;
							rot_q <= 1'b1;
						end
						hda_pkg::TAG_S1: begin
							t1_q <= rnd30;
							mul_a_q <= ACC_W'(mag_s(s2_q));
							mul_b_q <= MB_W'(mag_s(s2_q));
							mul_neg_q <= 1'b0;
							mul_tag_q <= hda_pkg::TAG_S2;
						end
						hda_pkg::TAG_S2: begin
							t2_q <= rnd30;
							mul_a_q <= ACC_W'(mag_s(c1_q));
							mul_b_q <= MB_W'(mag_s(c2_q));
							mul_neg_q <= c1_q[SW-1] ^ c2_q[SW-1];
							mul_tag_q <= hda_pkg::TAG_C;
						end
						hda_pkg::TAG_C: begin
							mul_a_q <= ACC_W'(mag_s(rnd30));
							mul_b_q <= MB_W'($unsigned(t2_q));
							mul_neg_q <= rnd30[SW-1];
							mul_tag_q <= hda_pkg::TAG_A;
						end
						hda_pkg::TAG_A: begin
							a_q <= a_clamp;
							sq_v_q <= SQ_W'({a_clamp, 30'd0});
							sq_res_q <= '0;
							sq_bit_q <= hda_pkg::SQ_BIT_START;
							sq_sel_q <= 1'b0;
						end
						hda_pkg::TAG_D: step_q <= step_sat;
						default: ;
					endcase
				end
			end
			hda_pkg::S_CORD: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= z_nx;
				it_q <= it_q + 1'b1;
				if (cord_done) begin
					mul_acc_q <= '0;
					if (rot_q) begin
						case (ang_q)
							hda_pkg::ANG_DLAT: s1_q <= sc_res;
							hda_pkg::ANG_DLON: s2_q <= sc_res;
							hda_pkg::ANG_LAT_A: c1_q <= sc_res;
							default: c2_q <= sc_res;
						endcase
						if (ang_q == hda_pkg::ANG_LAT_B) begin
							mul_a_q <= ACC_W'(mag_s(s1_q));
							mul_b_q <= MB_W'(mag_s(s1_q));
							mul_neg_q <= 1'b0;
							mul_tag_q <= hda_pkg::TAG_S1;
						end else begin
							ang_q <= ang_q + 1'b1;
						end
					end else begin
						// scale the central angle by the diameter, negative clamps to zero
						mul_a_q <= z_nx[CW-1] ? '0 : ACC_W'($unsigned(z_nx));
						mul_b_q <= hda_pkg::DIAMETER_KM;
						mul_neg_q <= 1'b0;
						mul_tag_q <= hda_pkg::TAG_D;
					end
				end
			end
			hda_pkg::S_SQRT: begin
				if (!sq_done) begin
					if (sq_ge)
						sq_v_q <= sq_v_q - sq_try;
					sq_res_q <= sq_res_nx;
					sq_bit_q <= sq_bit_q >> 2;
				end else if (!sq_sel_q) begin
					ry_q <= sq_res_nx[A_W-1:0];
					sq_v_q <= SQ_W'({hda_pkg::ONE_Q30 - a_q, 30'd0});
					sq_res_q <= '0;
					sq_bit_q <= hda_pkg::SQ_BIT_START;
					sq_sel_q <= 1'b1;
				end else begin
					x_q <= $signed(CW'({sq_res_nx[A_W-1:0], 10'd0}));
					y_q <= $signed(CW'({ry_q, 10'd0}));
					z_q <= '0;
					it_q <= '0;
					rot_q <= 1'b0;
				end
			end
			hda_pkg::S_DONE: begin
				if (!out_valid_q || out_ready)
					out_step_q <= step_q;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == hda_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign step_distance = out_step_q;
	assign total_distance = total_q;

	// Checks
	`include "haversine_distance_accumulator_assert.svh"

	`HDA_ASSERT_NEXT(a_accept_starts_reduction, in_valid && in_ready, state_q == hda_pkg::S_RED)
	`HDA_ASSERT_NEXT(a_total_never_drops, 1'b1, total_q >= $past(total_q))
	`HDA_ASSERT_NEXT(a_done_waits, state_q == hda_pkg::S_DONE && out_valid_q && !out_ready, state_q == hda_pkg::S_DONE)
	`HDA_ASSERT_NOW(a_iter_in_range, state_q == hda_pkg::S_CORD, it_q <= ITER_LAST)

endmodule
